// ----- src/gclp_pkg.sv -----
// Shared types and constants for the G-code line word parser.
`default_nettype none

package gclp_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int FRAC_DIGITS = 3;
    localparam int MAG_W       = VALUE_WIDTH - 1;
    localparam int FCNT_W      = (FRAC_DIGITS > 0) ? $clog2(FRAC_DIGITS + 1) : 1;
    localparam int NUM_WORDS   = 6;

    localparam logic [MAG_W-1:0] MAX_MAG = '1;

    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_Y     = 8'h59;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_I     = 8'h49;
    localparam logic [7:0] CH_J     = 8'h4A;
    localparam logic [7:0] CH_F     = 8'h46;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [7:0] POS_MAX  = 8'hFF;

    typedef enum logic [2:0] {
        K_OTHER,
        K_SEMI,
        K_WORD,
        K_SPACE,
        K_MINUS,
        K_POINT,
        K_DIGIT
    } t_kind;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_end;
    } t_in_item;

    typedef struct packed {
        t_kind      kind;
        logic [2:0] widx;
        logic [3:0] digit;
        logic       last;
        logic [7:0] letter;
        logic [6:0] number;
        logic       empty_line;
    } t_op;

    typedef struct packed {
        logic                  close;
        logic [2:0]            widx;
        logic [MAG_W-1:0]      mag;
        logic [FCNT_W-1:0]     pad;
        logic                  minus;
        logic                  last;
        logic [7:0]            letter;
        logic [6:0]            number;
        logic [NUM_WORDS-1:0]  mask;
        logic                  empty_line;
    } t_tok;

    typedef struct packed {
        logic [7:0]                    command_letter;
        logic [6:0]                    command_code;
        logic [5:0]                    present_mask;
        logic signed [VALUE_WIDTH-1:0] x_value;
        logic signed [VALUE_WIDTH-1:0] y_value;
        logic signed [VALUE_WIDTH-1:0] z_value;
        logic signed [VALUE_WIDTH-1:0] i_value;
        logic signed [VALUE_WIDTH-1:0] j_value;
        logic signed [VALUE_WIDTH-1:0] f_value;
        logic                          empty_line;
    } t_result;

endpackage

`default_nettype wire

// ----- src/gcode_line_word_parser.sv -----
// Path: after its last character is taken, a line's result passes through the op queue,
//   the execute stage, one pad stage per fraction digit and the result queue.
// Throughput: one character per cycle while the op queue is not full; one result per line, held in a two-entry queue.
// The back end stalls only when a finished result finds the result queue full.
// Reset (synchronous, active low) empties both queues and clears all line state.
`default_nettype none

module gcode_line_word_parser (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                push,
    input  gclp_pkg::t_in_item i_item,
    output logic               full,
    input  wire                pop,
    output logic               empty,
    output gclp_pkg::t_result  o_result
);
    import gclp_pkg::*;

    t_op  front_op;
    t_op  q_op;
    logic accept;
    logic q_empty;
    logic q_rd;

    assign accept = push && !full;

    gclp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_op     (front_op)
    );

    gclp_op_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_op    (front_op),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_op    (q_op)
    );

    gclp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (!q_empty),
        .i_op       (q_op),
        .o_op_rd    (q_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

    a_empty_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.empty_line) |->
            (o_result.command_letter == 8'd0 && o_result.present_mask == 6'd0))
        else $error("empty line carries a letter or words");

    a_number_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_result.command_code <= 7'd99))
        else $error("command number out of range");

    a_absent_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.present_mask[0]) |-> (o_result.x_value == '0))
        else $error("absent X word has a nonzero value");

    a_absent_f: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_result.present_mask[5]) |-> (o_result.f_value == '0))
        else $error("absent F word has a nonzero value");

endmodule

`default_nettype wire

// ----- src/gclp_front.sv -----
// Front end: comment tracking, command letter/number capture and character classification.
`default_nettype none

module gclp_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_accept,
    input  gclp_pkg::t_in_item i_item,
    output gclp_pkg::t_op     o_op
);
    import gclp_pkg::*;

    logic       r_in_comment, n_in_comment;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_letter, n_letter;
    logic [6:0] r_number, n_number;

    logic [7:0] c;
    logic       is_digit;
    logic [3:0] dval;
    t_op        op;

    always_comb begin
        c        = i_item.char_code;
        is_digit = c inside {[CH_ZERO:CH_NINE]};
        dval     = is_digit ? c[3:0] : 4'd0;

        n_in_comment = r_in_comment;
        n_pos        = r_pos;
        n_letter     = r_letter;
        n_number     = r_number;

        op       = '0;
        op.kind  = K_OTHER;
        op.digit = dval;

        if (!r_in_comment) begin
            if (c == CH_SEMI) begin
                op.kind      = K_SEMI;
                n_in_comment = 1'b1;
            end else begin
                if (r_pos == 8'd0) begin
                    n_letter = c;
                end else if (r_pos == 8'd1) begin
                    n_number = r_number + 7'(dval) * 7'd10;
                end else if (r_pos == 8'd2) begin
                    n_number = r_number + 7'(dval);
                end
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + 8'd1;
                end

                case (c)
                    CH_X: begin
                        op.kind = K_WORD;
                        op.widx = 3'd0;
                    end
                    CH_Y: begin
                        op.kind = K_WORD;
                        op.widx = 3'd1;
                    end
                    CH_Z: begin
                        op.kind = K_WORD;
                        op.widx = 3'd2;
                    end
                    CH_I: begin
                        op.kind = K_WORD;
                        op.widx = 3'd3;
                    end
                    CH_J: begin
                        op.kind = K_WORD;
                        op.widx = 3'd4;
                    end
                    CH_F: begin
                        op.kind = K_WORD;
                        op.widx = 3'd5;
                    end
                    CH_SPACE: op.kind = K_SPACE;
                    CH_MINUS: op.kind = K_MINUS;
                    CH_POINT: op.kind = K_POINT;
                    default: begin
                        if (is_digit) begin
                            op.kind = K_DIGIT;
                        end
                    end
                endcase
            end
        end

        op.last       = i_item.line_end;
        op.letter     = n_letter;
        op.number     = n_number;
        op.empty_line = (n_pos == 8'd0);
        o_op          = op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_comment <= 1'b0;
            r_pos        <= '0;
            r_letter     <= '0;
            r_number     <= '0;
        end else if (i_accept) begin
            if (i_item.line_end) begin
                // line done: start the next one clean
                r_in_comment <= 1'b0;
                r_pos        <= '0;
                r_letter     <= '0;
                r_number     <= '0;
            end else begin
                r_in_comment <= n_in_comment;
                r_pos        <= n_pos;
                r_letter     <= n_letter;
                r_number     <= n_number;
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/gclp_op_queue.sv -----
// Two-entry queue of classified characters between front and back end.
`default_nettype none

module gclp_op_queue (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_wr,
    input  gclp_pkg::t_op i_op,
    output logic          o_full,
    input  wire           i_rd,
    output logic          o_empty,
    output gclp_pkg::t_op o_op
);
    import gclp_pkg::*;

    t_op        r_mem [0:1];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr_en, rd_en;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_op    = r_mem[r_rp];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- src/gclp_back.sv -----
// Back end: word state, value accumulation, fraction padding, value store and result queue.
`default_nettype none

module gclp_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_op_valid,
    input  gclp_pkg::t_op     i_op,
    output logic              o_op_rd,
    input  wire               i_pop,
    output logic              o_empty,
    output gclp_pkg::t_result o_result
);
    import gclp_pkg::*;

    // min(10 * acc + d, MAX_MAG)
    function automatic logic [MAG_W-1:0] ten_plus(input logic [MAG_W-1:0] acc,
                                                  input logic [3:0] d);
        logic [MAG_W+3:0] s;
        s = ((MAG_W + 4)'(acc) << 3) + ((MAG_W + 4)'(acc) << 1) + (MAG_W + 4)'(d);
        return (s > (MAG_W + 4)'(MAX_MAG)) ? MAX_MAG : s[MAG_W-1:0];
    endfunction

    function automatic t_tok pad_step(input t_tok t);
        t_tok r;
        r = t;
        if (t.pad != '0) begin
            r.mag = ten_plus(t.mag, 4'd0);
            r.pad = t.pad - FCNT_W'(1);
        end
        return r;
    endfunction

    // execute-stage word state
    logic [NUM_WORDS-1:0] r_seen, a_seen;
    logic [2:0]           r_active, a_active;
    logic [MAG_W-1:0]     r_acc, a_acc;
    logic [FCNT_W-1:0]    r_fcnt, a_fcnt;
    logic                 r_after_pt, a_after_pt;
    logic                 r_minus, a_minus;

    // token pipeline: stage 0 from execute, then one stage per fraction digit
    logic r_tv  [0:FRAC_DIGITS];
    t_tok r_tok [0:FRAC_DIGITS];

    logic [VALUE_WIDTH-1:0] r_wv [0:NUM_WORDS-1];
    logic [VALUE_WIDTH-1:0] wv_m [0:NUM_WORDS-1];

    t_result    r_oq [0:1];
    logic       r_oq_wp, r_oq_rp;
    logic [1:0] r_oq_cnt;

    logic                   adv;
    logic                   close1;
    logic                   hit_new;
    t_tok                   tok;
    t_tok                   fin;
    logic                   fin_v;
    logic [VALUE_WIDTH-1:0] fin_value;
    t_result                res;
    logic                   oq_push, oq_pop;

    assign fin   = r_tok[FRAC_DIGITS];
    assign fin_v = r_tv[FRAC_DIGITS];

    // stall the whole back end only when a result has nowhere to go
    assign adv     = !(fin_v && fin.last && (r_oq_cnt == 2'd2));
    assign o_op_rd = adv && i_op_valid;

    always_comb begin
        a_seen     = r_seen;
        a_active   = r_active;
        a_acc      = r_acc;
        a_fcnt     = r_fcnt;
        a_after_pt = r_after_pt;
        a_minus    = r_minus;
        close1     = 1'b0;
        hit_new    = (i_op.kind == K_WORD) && !r_seen[i_op.widx];

        if (i_op.kind == K_SEMI) begin
            close1     = (r_active != 3'd0);
            a_active   = 3'd0;
            a_acc      = '0;
            a_fcnt     = '0;
            a_after_pt = 1'b0;
            a_minus    = 1'b0;
        end else if (hit_new) begin
            close1             = (r_active != 3'd0);
            a_active           = i_op.widx + 3'd1;
            a_seen[i_op.widx]  = 1'b1;
            a_acc              = '0;
            a_fcnt             = '0;
            a_after_pt         = 1'b0;
            a_minus            = 1'b0;
        end else if (r_active != 3'd0) begin
            case (i_op.kind)
                K_SPACE: begin
                    close1     = 1'b1;
                    a_active   = 3'd0;
                    a_acc      = '0;
                    a_fcnt     = '0;
                    a_after_pt = 1'b0;
                    a_minus    = 1'b0;
                end
                K_MINUS: a_minus    = 1'b1;
                K_POINT: a_after_pt = 1'b1;
                K_DIGIT: begin
                    if (!r_after_pt) begin
                        a_acc = ten_plus(r_acc, i_op.digit);
                    end else if (r_fcnt < FCNT_W'(FRAC_DIGITS)) begin
                        a_acc  = ten_plus(r_acc, i_op.digit);
                        a_fcnt = r_fcnt + FCNT_W'(1);
                    end
                end
                default: ;
            endcase
        end

        // a char closes at most one word with a nonzero effect: a word it just
        // opened is still zero when the line end closes it
        tok            = '0;
        tok.close      = close1 || (i_op.last && (a_active != 3'd0));
        if (close1) begin
            tok.widx  = r_active - 3'd1;
            tok.mag   = r_acc;
            tok.pad   = FCNT_W'(FRAC_DIGITS) - r_fcnt;
            tok.minus = r_minus;
        end else begin
            tok.widx  = a_active - 3'd1;
            tok.mag   = a_acc;
            tok.pad   = FCNT_W'(FRAC_DIGITS) - a_fcnt;
            tok.minus = a_minus;
        end
        tok.last       = i_op.last;
        tok.letter     = i_op.letter;
        tok.number     = i_op.number;
        tok.mask       = a_seen;
        tok.empty_line = i_op.empty_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen     <= '0;
            r_active   <= '0;
            r_acc      <= '0;
            r_fcnt     <= '0;
            r_after_pt <= 1'b0;
            r_minus    <= 1'b0;
        end else if (adv) begin
            if (i_op_valid) begin
                if (i_op.last) begin
                    r_seen     <= '0;
                    r_active   <= '0;
                    r_acc      <= '0;
                    r_fcnt     <= '0;
                    r_after_pt <= 1'b0;
                    r_minus    <= 1'b0;
                end else begin
                    r_seen     <= a_seen;
                    r_active   <= a_active;
                    r_acc      <= a_acc;
                    r_fcnt     <= a_fcnt;
                    r_after_pt <= a_after_pt;
                    r_minus    <= a_minus;
                end
            end
        end
    end

    // scale missing fraction digits, one times-ten per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= FRAC_DIGITS; k++) begin
                r_tv[k] <= 1'b0;
            end
        end else if (adv) begin
            r_tv[0] <= i_op_valid;
            for (int k = 1; k <= FRAC_DIGITS; k++) begin
                r_tv[k] <= r_tv[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tok[0] <= tok;
            for (int k = 1; k <= FRAC_DIGITS; k++) begin
                r_tok[k] <= pad_step(r_tok[k-1]);
            end
        end
    end

    always_comb begin
        fin_value = fin.minus ? (VALUE_WIDTH'(0) - {1'b0, fin.mag}) : {1'b0, fin.mag};
        for (int k = 0; k < NUM_WORDS; k++) begin
            wv_m[k] = (fin.close && (fin.widx == 3'(k))) ? fin_value : r_wv[k];
        end
        res                = '0;
        res.command_letter = fin.letter;
        res.command_code   = fin.number;
        res.present_mask   = fin.mask;
        res.x_value        = wv_m[0];
        res.y_value        = wv_m[1];
        res.z_value        = wv_m[2];
        res.i_value        = wv_m[3];
        res.j_value        = wv_m[4];
        res.f_value        = wv_m[5];
        res.empty_line     = fin.empty_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_wv[k] <= '0;
            end
        end else if (adv && fin_v) begin
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_wv[k] <= fin.last ? '0 : wv_m[k];
            end
        end
    end

    assign oq_push  = adv && fin_v && fin.last;
    assign oq_pop   = i_pop && (r_oq_cnt != 2'd0);
    assign o_empty  = (r_oq_cnt == 2'd0);
    assign o_result = r_oq[r_oq_rp];

    always_ff @(posedge i_clk) begin
        if (oq_push) begin
            r_oq[r_oq_wp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wp  <= 1'b0;
            r_oq_rp  <= 1'b0;
            r_oq_cnt <= '0;
        end else begin
            if (oq_push) begin
                r_oq_wp <= ~r_oq_wp;
            end
            if (oq_pop) begin
                r_oq_rp <= ~r_oq_rp;
            end
            case ({oq_push, oq_pop})
                2'b10:   r_oq_cnt <= r_oq_cnt + 2'd1;
                2'b01:   r_oq_cnt <= r_oq_cnt - 2'd1;
                default: r_oq_cnt <= r_oq_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- test/tb_gcode_line_word_parser.sv -----
// Testbench for the G-code line word parser: directed lines, backpressure and random lines.
`timescale 1ns / 1ps

module tb_gcode_line_word_parser;

    import gclp_pkg::*;

    localparam longint MAG_LIMIT = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
    localparam string  WORD_CHARS = "XYZIJF";
    localparam int     DRAIN_CYCLES = FRAC_DIGITS + 20;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    t_in_item  i_item;
    t_result   o_result;

    gcode_line_word_parser uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Parser state mirrored by the testbench
    int                     line_pos;
    bit                     in_remark;
    int                     cur_word;
    logic [NUM_WORDS-1:0]   words_seen;
    logic [VALUE_WIDTH-1:0] word_val [NUM_WORDS];
    longint                 mag_acc;
    int                     frac_cnt;
    bit                     seen_point;
    bit                     is_negative;
    logic [7:0]             cmd_letter;
    int                     cmd_number;

    t_result    pending_lines [$];
    logic [7:0] line_buf [$];
    int         mismatches = 0;
    int         chars_sent = 0;
    bit         idle_on = 1'b1;
    int         pop_hold = 0;

    function automatic longint mul10_add_sat(longint acc, longint d);
        if (acc > (MAG_LIMIT - d) / 10)
            return MAG_LIMIT;
        return acc * 10 + d;
    endfunction

    function automatic int digit_val(logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) ? int'(c - CH_ZERO) : 0;
    endfunction

    function automatic int letter_slot(logic [7:0] c);
        for (int k = 0; k < NUM_WORDS; k++)
            if (c == WORD_CHARS[k])
                return k;
        return -1;
    endfunction

    function automatic void clear_word();
        cur_word    = 0;
        mag_acc     = 0;
        frac_cnt    = 0;
        seen_point  = 1'b0;
        is_negative = 1'b0;
    endfunction

    function automatic void close_word();
        longint v;
        if (cur_word != 0) begin
            v = mag_acc;
            for (int k = frac_cnt; k < FRAC_DIGITS; k++)
                v = mul10_add_sat(v, 0);
            if (is_negative)
                v = -v;
            word_val[cur_word - 1] = v[VALUE_WIDTH-1:0];
        end
        clear_word();
    endfunction

    function automatic void reset_line_state();
        line_pos   = 0;
        in_remark  = 1'b0;
        words_seen = '0;
        cmd_letter = '0;
        cmd_number = 0;
        foreach (word_val[k])
            word_val[k] = '0;
        clear_word();
    endfunction

    // Advance the parser by one character; queue the line's result at its end
    function automatic void parse_char(logic [7:0] c, logic last);
        int      w;
        t_result r;
        if (!in_remark) begin
            if (c == CH_SEMI) begin
                close_word();
                in_remark = 1'b1;
            end else begin
                if (line_pos == 0)
                    cmd_letter = c;
                else if (line_pos == 1)
                    cmd_number += 10 * digit_val(c);
                else if (line_pos == 2)
                    cmd_number += digit_val(c);
                if (line_pos < 255)
                    line_pos++;
                w = letter_slot(c);
                if (w >= 0 && !words_seen[w]) begin
                    close_word();
                    cur_word      = w + 1;
                    words_seen[w] = 1'b1;
                end else if (cur_word != 0) begin
                    if (c == CH_SPACE) begin
                        close_word();
                    end else if (c == CH_MINUS) begin
                        is_negative = 1'b1;
                    end else if (c == CH_POINT) begin
                        seen_point = 1'b1;
                    end else if (c >= CH_ZERO && c <= CH_NINE) begin
                        if (!seen_point) begin
                            mag_acc = mul10_add_sat(mag_acc, digit_val(c));
                        end else if (frac_cnt < FRAC_DIGITS) begin
                            mag_acc = mul10_add_sat(mag_acc, digit_val(c));
                            frac_cnt++;
                        end
                    end
                end
            end
        end
        if (last) begin
            close_word();
            r.command_letter = cmd_letter;
            r.command_code   = 7'(cmd_number);
            r.present_mask   = words_seen;
            r.x_value        = word_val[0];
            r.y_value        = word_val[1];
            r.z_value        = word_val[2];
            r.i_value        = word_val[3];
            r.j_value        = word_val[4];
            r.f_value        = word_val[5];
            r.empty_line     = (line_pos == 0);
            pending_lines.push_back(r);
            reset_line_state();
        end
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : check_result
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (pending_lines.size() == 0) begin
                $error("result with no line pending");
                mismatches++;
            end else begin
                want = pending_lines.pop_front();
                check_field("command_letter", want.command_letter, o_result.command_letter);
                check_field("command_code", want.command_code, o_result.command_code);
                check_field("present_mask", want.present_mask, o_result.present_mask);
                check_field("x_value", want.x_value, o_result.x_value);
                check_field("y_value", want.y_value, o_result.y_value);
                check_field("z_value", want.z_value, o_result.z_value);
                check_field("i_value", want.i_value, o_result.i_value);
                check_field("j_value", want.j_value, o_result.j_value);
                check_field("f_value", want.f_value, o_result.f_value);
                check_field("empty_line", want.empty_line, o_result.empty_line);
            end
        end
    end

    // Result side: random idling, plus a long hold when requested
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (pop_hold > 0) begin
                pop <= 1'b0;
                pop_hold--;
            end else begin
                pop <= !(idle_on && $urandom_range(99) < 19);
            end
        end
    end

    // Enter and leave at a falling edge
    task automatic send_char(input logic [7:0] c, input logic last);
        while (idle_on && $urandom_range(99) < 19) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push   <= 1'b1;
        i_item <= '{char_code: c, line_end: last};
        do
            @(posedge i_clk);
        while (full);
        parse_char(c, last);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        for (int k = 0; k < line_buf.size(); k++)
            send_char(line_buf[k], k == line_buf.size() - 1);
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++)
            line_buf.push_back(s[k]);
    endtask

    task automatic send_text(input string s);
        line_buf = {};
        put_text(s);
        send_line();
    endtask

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    task automatic put_value();
        int n;
        if ($urandom_range(4) == 0)
            line_buf.push_back(CH_MINUS);
        n = ($urandom_range(7) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 4);
        repeat (n) line_buf.push_back(pick("0123456789"));
        if ($urandom_range(4) < 3) begin
            line_buf.push_back(CH_POINT);
            n = $urandom_range(0, 5);
            repeat (n) line_buf.push_back(pick("0123456789"));
        end
        if ($urandom_range(11) == 0)
            line_buf.push_back(pick("a-.#"));
    endtask

    task automatic make_random_line(input bit force_long);
        int shape;
        int n;
        line_buf = {};
        shape = force_long ? 99 : $urandom_range(99);
        if (shape < 78) begin
            line_buf.push_back(pick("GGGMTXF;"));
            repeat (2)
                line_buf.push_back(($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                                             : pick("0123456789"));
            n = $urandom_range(0, 6);
            repeat (n) begin
                if ($urandom_range(3) != 0)
                    line_buf.push_back(CH_SPACE);
                line_buf.push_back(pick("XYZIJFXYZIJFKE"));
                put_value();
            end
            if ($urandom_range(7) == 0) begin
                line_buf.push_back(CH_SEMI);
                n = $urandom_range(0, 5);
                repeat (n) line_buf.push_back(pick("XYZ01-. ;"));
            end
            // Cut the line short now and then
            if ($urandom_range(9) == 0) begin
                n = $urandom_range(1, line_buf.size());
                while (line_buf.size() > n)
                    void'(line_buf.pop_back());
            end
        end else if (shape < 99) begin
            n = $urandom_range(1, 12);
            repeat (n)
                line_buf.push_back($urandom_range(1) ? 8'($urandom_range(255))
                                                     : pick(" -.;0123456789XYZIJF"));
        end else begin
            n = $urandom_range(256, 300);
            repeat (n)
                line_buf.push_back(($urandom_range(15) == 0) ? 8'($urandom_range(255))
                                                              : pick("0123456789 .-XYZIJF"));
        end
        if (line_buf.size() == 0)
            line_buf.push_back(8'($urandom_range(255)));
    endtask

    task automatic run_random_lines(input int n_chars);
        int stop_at;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at) begin
            make_random_line(1'b0);
            send_line();
        end
    endtask

    task automatic test_directed_lines();
        send_text(";");
        send_text("G01X-1.5;Y");
        send_text("F3000000");
        send_text("Y-.1234Z");
        send_text("J1..a2 JI-");
        line_buf = {8'hFF, 8'h00};
        send_line();
    endtask

    // Hold the result side while short lines keep coming, so the input stalls
    task automatic test_result_backpressure();
        pop_hold = 300;
        repeat (40) send_text("G1");
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        run_random_lines(300);
        idle_on = 1'b1;
    endtask

    task automatic test_random_lines();
        make_random_line(1'b1);
        send_line();
        run_random_lines(750);
    endtask

    initial begin
        i_rst_n = 1'b0;
        push    = 1'b0;
        pop     = 1'b0;
        i_item  = '0;
        reset_line_state();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_lines();
        test_result_backpressure();
        test_steady_stream();
        test_random_lines();
        push <= 1'b0;

        while (pending_lines.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending_lines.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- gcode_line_word_parser.f -----
src/gclp_pkg.sv
src/gclp_front.sv
src/gclp_op_queue.sv
src/gclp_back.sv
src/gcode_line_word_parser.sv
test/tb_gcode_line_word_parser.sv
